// ===== rtl/core/pobc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pobc_pkg;

    localparam int unsigned MAX_BOXES_DEF = 16;

    localparam int unsigned COORD_W = 20;
    localparam int unsigned DIM_W   = 16;
    localparam int unsigned ROT_W   = 16;
    localparam int unsigned HIT_W   = 4;
    localparam int unsigned COUNT_W = 5;

    localparam logic [1:0] OP_CLEAR    = 2'd0;
    localparam logic [1:0] OP_LOAD     = 2'd1;
    localparam logic [1:0] OP_CLASSIFY = 2'd2;

    // One row of the box table: centre, extents and rotation.
    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic        [DIM_W-1:0]   len;
        logic        [DIM_W-1:0]   wid;
        logic        [DIM_W-1:0]   hgt;
        logic signed [ROT_W-1:0]   rcos;
        logic signed [ROT_W-1:0]   rsin;
    } box_entry_t;

    typedef struct packed {
        logic accept;
        logic scan_rd;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic table_empty;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/pobc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pobc_datapath #(
    parameter int unsigned MAX_BOXES = pobc_pkg::MAX_BOXES_DEF,
    parameter int unsigned IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1,
    parameter int unsigned CNT_W     = $clog2(MAX_BOXES + 1)
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire pobc_pkg::dp_cmd_t                 cmd,
    input  wire logic [IDX_W-1:0]                  scan_addr,
    output pobc_pkg::dp_stat_t                     stat,
    output logic [CNT_W-1:0]                       held,
    input  wire logic [1:0]                        s_opcode,
    input  wire logic signed [pobc_pkg::COORD_W-1:0] s_pos_x,
    input  wire logic signed [pobc_pkg::COORD_W-1:0] s_pos_y,
    input  wire logic signed [pobc_pkg::COORD_W-1:0] s_pos_z,
    input  wire logic [pobc_pkg::DIM_W-1:0]        s_box_length,
    input  wire logic [pobc_pkg::DIM_W-1:0]        s_box_width,
    input  wire logic [pobc_pkg::DIM_W-1:0]        s_box_height,
    input  wire logic signed [pobc_pkg::ROT_W-1:0] s_rot_cos,
    input  wire logic signed [pobc_pkg::ROT_W-1:0] s_rot_sin,
    output logic                                   m_status,
    output logic                                   m_inside_res,
    output logic [pobc_pkg::HIT_W-1:0]             m_hit_index,
    output logic [pobc_pkg::COUNT_W-1:0]           m_box_count
);

    localparam int unsigned CW = pobc_pkg::COORD_W;
    localparam int unsigned DW = CW + 1;                    // coordinate difference
    localparam int unsigned PW = DW + pobc_pkg::ROT_W;      // one product
    localparam int unsigned LW = PW + 1;                    // rotated coordinate
    localparam int unsigned ZW = DW + 2;                    // doubled z difference
    localparam int unsigned SH = pobc_pkg::ROT_W - 3;       // half dimension in Q.14

    pobc_pkg::box_entry_t mem_q [MAX_BOXES];

    logic [CNT_W-1:0]     held_reg;
    logic                 full;
    logic                 status_reg;
    logic signed [CW-1:0] px_reg, py_reg, pz_reg;

    // stage 1: table read
    logic                 v1_reg;
    logic [IDX_W-1:0]     idx1_reg;
    pobc_pkg::box_entry_t ent_reg;

    // stage 2: differences
    logic                 v2_reg;
    logic [IDX_W-1:0]     idx2_reg;
    logic signed [DW-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [DW-1:0] dx_next, dy_next, dz_next;
    logic signed [pobc_pkg::ROT_W-1:0] c2_reg, s2_reg;
    logic [pobc_pkg::DIM_W-1:0] len2_reg, wid2_reg, hgt2_reg;

    // stage 3: products
    logic                 v3_reg;
    logic [IDX_W-1:0]     idx3_reg;
    logic signed [PW-1:0] cdx_reg, sdy_reg, cdy_reg, sdx_reg;
    logic signed [PW-1:0] cdx_next, sdy_next, cdy_next, sdx_next;
    logic signed [ZW-1:0] dz2, hz;
    logic                 zok3_reg, zok_next;
    logic [pobc_pkg::DIM_W-1:0] len3_reg, wid3_reg;

    // stage 4: rotated coordinates
    logic                 v4_reg;
    logic [IDX_W-1:0]     idx4_reg;
    logic signed [LW-1:0] lx_reg, ly_reg, lx_next, ly_next;
    logic                 zok4_reg;
    logic [pobc_pkg::DIM_W-1:0] len4_reg, wid4_reg;

    logic signed [LW-1:0] bx, by;
    logic                 box_hit;
    logic                 found_reg;
    logic [IDX_W-1:0]     found_idx_reg;

    assign full = (held_reg == CNT_W'(MAX_BOXES));
    assign held = held_reg;
    assign stat.pipe_busy   = v1_reg | v2_reg | v3_reg | v4_reg;
    assign stat.table_empty = (held_reg == '0);

    always_comb begin
        dx_next  = {px_reg[CW-1], px_reg} - {ent_reg.cx[CW-1], ent_reg.cx};
        dy_next  = {py_reg[CW-1], py_reg} - {ent_reg.cy[CW-1], ent_reg.cy};
        dz_next  = {pz_reg[CW-1], pz_reg} - {ent_reg.cz[CW-1], ent_reg.cz};
        cdx_next = c2_reg * dx_reg;
        sdy_next = s2_reg * dy_reg;
        cdy_next = c2_reg * dy_reg;
        sdx_next = s2_reg * dx_reg;
        dz2      = {dz_reg[DW-1], dz_reg, 1'b0};
        hz       = {{(ZW - pobc_pkg::DIM_W){1'b0}}, hgt2_reg};
        zok_next = (dz2 <= hz) && (dz2 >= -hz);
        lx_next  = cdx_reg + sdy_reg;
        ly_next  = cdy_reg - sdx_reg;
        bx       = {{(LW - pobc_pkg::DIM_W - SH){1'b0}}, len4_reg, {SH{1'b0}}};
        by       = {{(LW - pobc_pkg::DIM_W - SH){1'b0}}, wid4_reg, {SH{1'b0}}};
        box_hit  = zok4_reg && (lx_reg <= bx) && (lx_reg >= -bx)
                            && (ly_reg <= by) && (ly_reg >= -by);
    end

    // table write and read port
    always_ff @(posedge aclk) begin
        if (cmd.accept && (s_opcode == pobc_pkg::OP_LOAD) && !full) begin
            mem_q[held_reg[IDX_W-1:0]] <= '{cx: s_pos_x, cy: s_pos_y, cz: s_pos_z,
                                            len: s_box_length, wid: s_box_width,
                                            hgt: s_box_height, rcos: s_rot_cos,
                                            rsin: s_rot_sin};
        end
        if (cmd.scan_rd) begin
            ent_reg <= mem_q[scan_addr];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.scan_rd;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (cmd.accept) begin
                found_reg <= 1'b0;
                if (s_opcode == pobc_pkg::OP_CLEAR) begin
                    held_reg <= '0;
                end else if ((s_opcode == pobc_pkg::OP_LOAD) && !full) begin
                    held_reg <= held_reg + CNT_W'(1);
                end
            end else if (v4_reg && box_hit && !found_reg) begin
                found_reg <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            px_reg        <= s_pos_x;
            py_reg        <= s_pos_y;
            pz_reg        <= s_pos_z;
            status_reg    <= (s_opcode == pobc_pkg::OP_LOAD) && full;
            found_idx_reg <= '0;
        end else if (v4_reg && box_hit && !found_reg) begin
            found_idx_reg <= idx4_reg;
        end

        idx1_reg <= scan_addr;

        idx2_reg <= idx1_reg;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        dz_reg   <= dz_next;
        c2_reg   <= ent_reg.rcos;
        s2_reg   <= ent_reg.rsin;
        len2_reg <= ent_reg.len;
        wid2_reg <= ent_reg.wid;
        hgt2_reg <= ent_reg.hgt;

        idx3_reg <= idx2_reg;
        cdx_reg  <= cdx_next;
        sdy_reg  <= sdy_next;
        cdy_reg  <= cdy_next;
        sdx_reg  <= sdx_next;
        zok3_reg <= zok_next;
        len3_reg <= len2_reg;
        wid3_reg <= wid2_reg;

        idx4_reg <= idx3_reg;
        lx_reg   <= lx_next;
        ly_reg   <= ly_next;
        zok4_reg <= zok3_reg;
        len4_reg <= len3_reg;
        wid4_reg <= wid3_reg;

        if (cmd.out_load) begin
            m_status     <= status_reg;
            m_inside_res <= found_reg;
            m_hit_index  <= pobc_pkg::HIT_W'(found_idx_reg);
            m_box_count  <= pobc_pkg::COUNT_W'(held_reg);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pobc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pobc_ctrl #(
    parameter int unsigned MAX_BOXES = pobc_pkg::MAX_BOXES_DEF,
    parameter int unsigned IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1,
    parameter int unsigned CNT_W     = $clog2(MAX_BOXES + 1)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_opcode,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output pobc_pkg::dp_cmd_t       cmd,
    output logic [IDX_W-1:0]        scan_addr,
    input  wire pobc_pkg::dp_stat_t stat,
    input  wire logic [CNT_W-1:0]   held
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESP
    } state_t;

    state_t           state_reg;
    logic             m_valid_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             accept;
    logic             out_free;

    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        accept       = s_valid && s_ready;
        out_free     = !m_valid_reg || m_ready;
        cnt_next     = cnt_reg + CNT_W'(1);
        cmd.accept   = accept;
        cmd.scan_rd  = (state_reg == ST_SCAN);
        cmd.out_load = (state_reg == ST_RESP) && out_free;
        scan_addr    = cnt_reg[IDX_W-1:0];
        m_valid      = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            if (m_valid_reg && m_ready && !cmd.out_load) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        cnt_reg <= '0;
                        if ((s_opcode == pobc_pkg::OP_CLASSIFY) && !stat.table_empty) begin
                            state_reg <= ST_SCAN;
                        end else begin
                            state_reg <= ST_RESP;
                        end
                    end
                end
                ST_SCAN: begin
                    // issue one table row per cycle
                    cnt_reg <= cnt_next;
                    if (cnt_next == held) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!stat.pipe_busy) begin
                        state_reg <= ST_RESP;
                    end
                end
                ST_RESP: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/point_in_oriented_box_classifier.sv =====
// Point-in-oriented-box classifier.
// Input channel (s_*): one beat per item. opcode 0 empties the box table,
// opcode 1 appends one box (centre, length/width/height, cos/sin in Q1.14),
// opcode 2 classifies the point on s_pos_x/y/z against the held boxes.
// Output channel (m_*): exactly one beat per input beat, in order.
// m_inside_res/m_hit_index give the first box containing the point,
// m_status flags a load dropped on a full table, m_box_count the table fill.
// Clear, load, the unused opcode and a classify on an empty table go from
// the input beat straight to the response state, which loads the output
// register. A classify on N >= 1 held boxes first scans: the scan reads one
// table row per cycle into a four-stage subtract/multiply/add/compare
// pipeline, then waits for the pipeline to drain. One item is in work at a
// time, so the next beat is taken as soon as the previous result sits in the
// output register, even when the receiver has not taken it yet.
// A stalled receiver holds the output register; the block then finishes the
// current item and waits before loading its result.
// Reset (aresetn low, synchronous) empties the table and drops any pending
// result. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module point_in_oriented_box_classifier #(
    parameter int unsigned MAX_BOXES = pobc_pkg::MAX_BOXES_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [1:0]                          s_opcode,
    input  wire logic signed [pobc_pkg::COORD_W-1:0] s_pos_x,
    input  wire logic signed [pobc_pkg::COORD_W-1:0] s_pos_y,
    input  wire logic signed [pobc_pkg::COORD_W-1:0] s_pos_z,
    input  wire logic [pobc_pkg::DIM_W-1:0]          s_box_length,
    input  wire logic [pobc_pkg::DIM_W-1:0]          s_box_width,
    input  wire logic [pobc_pkg::DIM_W-1:0]          s_box_height,
    input  wire logic signed [pobc_pkg::ROT_W-1:0]   s_rot_cos,
    input  wire logic signed [pobc_pkg::ROT_W-1:0]   s_rot_sin,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_status,
    output logic                                     m_inside_res,
    output logic [pobc_pkg::HIT_W-1:0]               m_hit_index,
    output logic [pobc_pkg::COUNT_W-1:0]             m_box_count
);

    localparam int unsigned IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_BOXES + 1);

    pobc_pkg::dp_cmd_t  cmd;
    pobc_pkg::dp_stat_t stat;
    logic [IDX_W-1:0]   scan_addr;
    logic [CNT_W-1:0]   held;

    pobc_ctrl #(
        .MAX_BOXES (MAX_BOXES),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_opcode  (s_opcode),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .scan_addr (scan_addr),
        .stat      (stat),
        .held      (held)
    );

    pobc_datapath #(
        .MAX_BOXES (MAX_BOXES),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .scan_addr    (scan_addr),
        .stat         (stat),
        .held         (held),
        .s_opcode     (s_opcode),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_pos_z      (s_pos_z),
        .s_box_length (s_box_length),
        .s_box_width  (s_box_width),
        .s_box_height (s_box_height),
        .s_rot_cos    (s_rot_cos),
        .s_rot_sin    (s_rot_sin),
        .m_status     (m_status),
        .m_inside_res (m_inside_res),
        .m_hit_index  (m_hit_index),
        .m_box_count  (m_box_count)
    );

endmodule

`default_nettype wire

// ===== rtl/core/pobc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pobc_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic                        m_status,
    input wire logic                        m_inside_res,
    input wire logic [pobc_pkg::HIT_W-1:0]  m_hit_index,
    input wire logic [pobc_pkg::COUNT_W-1:0] m_box_count
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_inside_res)
                                && $stable(m_hit_index) && $stable(m_box_count))
        else $error("output beat changed while stalled");

    // a dropped load never reports a hit
    a_status_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> !m_inside_res && (m_hit_index == '0))
        else $error("dropped load reported a hit");

    // a miss carries index zero
    a_miss_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_inside_res |-> (m_hit_index == '0))
        else $error("miss with nonzero hit index");

    // reset drops any pending result
    a_reset_flush: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind point_in_oriented_box_classifier pobc_checker u_pobc_checker (.*);

`default_nettype wire

// ===== bench/box_result_checker.sv =====
`timescale 1ns / 1ps

module box_result_checker #(
    parameter int unsigned MAX_BOXES = pobc_pkg::MAX_BOXES_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    input  wire logic                                s_ready,
    input  wire logic [1:0]                          s_opcode,
    input  wire logic signed [pobc_pkg::COORD_W-1:0] s_pos_x,
    input  wire logic signed [pobc_pkg::COORD_W-1:0] s_pos_y,
    input  wire logic signed [pobc_pkg::COORD_W-1:0] s_pos_z,
    input  wire logic [pobc_pkg::DIM_W-1:0]          s_box_length,
    input  wire logic [pobc_pkg::DIM_W-1:0]          s_box_width,
    input  wire logic [pobc_pkg::DIM_W-1:0]          s_box_height,
    input  wire logic signed [pobc_pkg::ROT_W-1:0]   s_rot_cos,
    input  wire logic signed [pobc_pkg::ROT_W-1:0]   s_rot_sin,
    input  wire logic                                m_valid,
    input  wire logic                                m_ready,
    input  wire logic                                m_status,
    input  wire logic                                m_inside_res,
    input  wire logic [pobc_pkg::HIT_W-1:0]          m_hit_index,
    input  wire logic [pobc_pkg::COUNT_W-1:0]        m_box_count,
    output int                                       fail_count,
    output int                                       pending_results,
    output int                                       hit_total,
    output int                                       drop_total
);

    import pobc_pkg::*;

    typedef struct packed {
        logic               status;
        logic               inside_res;
        logic [HIT_W-1:0]   hit_index;
        logic [COUNT_W-1:0] box_count;
    } box_verdict_t;

    box_entry_t   box_table [MAX_BOXES];
    int unsigned  table_fill;
    box_verdict_t verdict_q [$];
    box_verdict_t want;

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Rotate the offset by the inverse angle and test against half extents.
    // Bounds are scaled by 2^13 so the Q1.14 products compare exactly.
    function automatic bit box_contains(input box_entry_t b, input longint px,
                                        input longint py, input longint pz);
        longint dx, dy, dz, c, s, lx, ly;
        dx = px - longint'($signed(b.cx));
        dy = py - longint'($signed(b.cy));
        dz = pz - longint'($signed(b.cz));
        c  = longint'($signed(b.rcos));
        s  = longint'($signed(b.rsin));
        lx = c * dx + s * dy;
        ly = c * dy - s * dx;
        return magnitude(lx) <= longint'(b.len) * 8192 &&
               magnitude(ly) <= longint'(b.wid) * 8192 &&
               2 * magnitude(dz) <= longint'(b.hgt);
    endfunction

    function automatic box_verdict_t predict_item(
        input logic [1:0]                op,
        input logic signed [COORD_W-1:0] px,
        input logic signed [COORD_W-1:0] py,
        input logic signed [COORD_W-1:0] pz,
        input logic [DIM_W-1:0]          len,
        input logic [DIM_W-1:0]          wid,
        input logic [DIM_W-1:0]          hgt,
        input logic signed [ROT_W-1:0]   rc,
        input logic signed [ROT_W-1:0]   rs
    );
        box_verdict_t v;
        box_entry_t   e;
        int unsigned  i;
        v = '0;
        case (op)
            OP_CLEAR: begin
                table_fill = 0;
            end
            OP_LOAD: begin
                if (table_fill < MAX_BOXES) begin
                    e.cx   = px;
                    e.cy   = py;
                    e.cz   = pz;
                    e.len  = len;
                    e.wid  = wid;
                    e.hgt  = hgt;
                    e.rcos = rc;
                    e.rsin = rs;
                    box_table[table_fill] = e;
                    table_fill++;
                end else begin
                    v.status = 1'b1;
                end
            end
            OP_CLASSIFY: begin
                for (i = 0; i < table_fill; i++) begin
                    if (box_contains(box_table[i], longint'(px), longint'(py),
                                     longint'(pz))) begin
                        v.inside_res = 1'b1;
                        v.hit_index  = i[HIT_W-1:0];
                        break;
                    end
                end
            end
            default: begin
            end
        endcase
        v.box_count = table_fill[COUNT_W-1:0];
        return v;
    endfunction

    task automatic check_field(input string field, input int unsigned exp_val,
                               input int unsigned got_val);
        if (exp_val != got_val) begin
            $error("%s mismatch: expected %0d, got %0d", field, exp_val, got_val);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            table_fill = 0;
            verdict_q.delete();
            fail_count = 0;
            hit_total  = 0;
            drop_total = 0;
        end else begin
            if (s_valid && s_ready) begin
                verdict_q.insert(verdict_q.size(),
                                 predict_item(s_opcode, s_pos_x, s_pos_y, s_pos_z,
                                              s_box_length, s_box_width,
                                              s_box_height, s_rot_cos, s_rot_sin));
            end
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    $error("result beat with no item outstanding");
                    fail_count++;
                end else begin
                    want = verdict_q.pop_front();
                    check_field("status", int'(want.status), int'(m_status));
                    check_field("inside_res", int'(want.inside_res),
                                int'(m_inside_res));
                    check_field("hit_index", int'(want.hit_index), int'(m_hit_index));
                    check_field("box_count", int'(want.box_count), int'(m_box_count));
                    hit_total  += int'(want.inside_res);
                    drop_total += int'(want.status);
                end
            end
        end
        pending_results <= verdict_q.size();
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    import pobc_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS = 410;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         IDLE_LIMIT   = 4000;
    localparam int         DRAIN_CYCLES = 32;

    typedef struct {
        logic [1:0]                opcode;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [DIM_W-1:0]          len;
        logic [DIM_W-1:0]          wid;
        logic [DIM_W-1:0]          hgt;
        logic signed [ROT_W-1:0]   rc;
        logic signed [ROT_W-1:0]   rs;
    } stim_item_t;

    logic                      aclk    = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [1:0]                s_opcode     = OP_CLEAR;
    logic signed [COORD_W-1:0] s_pos_x      = '0;
    logic signed [COORD_W-1:0] s_pos_y      = '0;
    logic signed [COORD_W-1:0] s_pos_z      = '0;
    logic [DIM_W-1:0]          s_box_length = '0;
    logic [DIM_W-1:0]          s_box_width  = '0;
    logic [DIM_W-1:0]          s_box_height = '0;
    logic signed [ROT_W-1:0]   s_rot_cos    = '0;
    logic signed [ROT_W-1:0]   s_rot_sin    = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic                      m_status;
    logic                      m_inside_res;
    logic [HIT_W-1:0]          m_hit_index;
    logic [COUNT_W-1:0]        m_box_count;

    int fail_count, pending_results, hit_total, drop_total;

    // Sender bookkeeping and a shadow of loaded boxes for aiming points.
    int          burst_left = 0;
    int          items_sent = 0;
    int          op_count [4];
    stim_item_t  shadow_box [MAX_BOXES_DEF];
    int          shadow_fill = 0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;
    int          rx_mode = 0;
    int          rx_phase_left = 0;
    int          rx_stall_left = 0;
    int          idle_cycles = 0;

    always #6 aclk = ~aclk;

    point_in_oriented_box_classifier u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_pos_x      (s_pos_x),
        .s_pos_y      (s_pos_y),
        .s_pos_z      (s_pos_z),
        .s_box_length (s_box_length),
        .s_box_width  (s_box_width),
        .s_box_height (s_box_height),
        .s_rot_cos    (s_rot_cos),
        .s_rot_sin    (s_rot_sin),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_inside_res (m_inside_res),
        .m_hit_index  (m_hit_index),
        .m_box_count  (m_box_count)
    );

    box_result_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .s_pos_z         (s_pos_z),
        .s_box_length    (s_box_length),
        .s_box_width     (s_box_width),
        .s_box_height    (s_box_height),
        .s_rot_cos       (s_rot_cos),
        .s_rot_sin       (s_rot_sin),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_inside_res    (m_inside_res),
        .m_hit_index     (m_hit_index),
        .m_box_count     (m_box_count),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .hit_total       (hit_total),
        .drop_total      (drop_total)
    );

    function automatic stim_item_t make_item(input logic [1:0] op, input int x,
                                             input int y, input int z,
                                             input int len, input int wid,
                                             input int hgt, input int rc,
                                             input int rs);
        stim_item_t it;
        it.opcode = op;
        it.x      = x[COORD_W-1:0];
        it.y      = y[COORD_W-1:0];
        it.z      = z[COORD_W-1:0];
        it.len    = len[DIM_W-1:0];
        it.wid    = wid[DIM_W-1:0];
        it.hgt    = hgt[DIM_W-1:0];
        it.rc     = rc[ROT_W-1:0];
        it.rs     = rs[ROT_W-1:0];
        return it;
    endfunction

    function automatic stim_item_t random_item();
        stim_item_t it;
        it.opcode = 2'($urandom_range(0, 3));
        it.x      = COORD_W'($urandom());
        it.y      = COORD_W'($urandom());
        it.z      = COORD_W'($urandom());
        it.len    = DIM_W'($urandom());
        it.wid    = DIM_W'($urandom());
        it.hgt    = DIM_W'($urandom());
        it.rc     = ROT_W'($urandom());
        it.rs     = ROT_W'($urandom());
        return it;
    endfunction

    function automatic logic signed [COORD_W-1:0] coord_clamp(input longint v);
        if (v > 524287)
            return 20'sd524287;
        if (v < -524288)
            return -20'sd524288;
        return v[COORD_W-1:0];
    endfunction

    function automatic longint rand_offset(input longint r);
        return longint'($urandom_range(0, 32'(2 * r))) - r;
    endfunction

    function automatic stim_item_t random_box();
        stim_item_t it;
        bit         big;
        it = random_item();
        it.opcode = OP_LOAD;
        big = ($urandom_range(0, 7) == 0);
        if (!big) begin
            it.x   = COORD_W'(int'($urandom_range(0, 40000)) - 20000);
            it.y   = COORD_W'(int'($urandom_range(0, 40000)) - 20000);
            it.z   = COORD_W'(int'($urandom_range(0, 4000)) - 2000);
            it.len = DIM_W'($urandom_range(0, 4000));
            it.wid = DIM_W'($urandom_range(0, 4000));
            it.hgt = DIM_W'($urandom_range(0, 1000));
        end
        case ($urandom_range(0, 7))
            0: begin it.rc = ROT_W'(16384);  it.rs = ROT_W'(0);      end
            1: begin it.rc = ROT_W'(0);      it.rs = ROT_W'(16384);  end
            2: begin it.rc = ROT_W'(-16384); it.rs = ROT_W'(0);      end
            3: begin it.rc = ROT_W'(0);      it.rs = ROT_W'(-16384); end
            4: begin it.rc = ROT_W'(11585);  it.rs = ROT_W'(11585);  end
            5: begin it.rc = ROT_W'(-11585); it.rs = ROT_W'(11585);  end
            6: begin
                it.rc = ROT_W'(int'($urandom_range(0, 32768)) - 16384);
                it.rs = ROT_W'(int'($urandom_range(0, 32768)) - 16384);
            end
            default: begin
            end
        endcase
        return it;
    endfunction

    // Aim a point at a held box; widen the spread now and then to land on the
    // faces and just past them.
    function automatic stim_item_t point_near(input stim_item_t b);
        stim_item_t p;
        longint     r, rz;
        p = random_item();
        p.opcode = OP_CLASSIFY;
        r  = longint'((b.len < b.wid) ? b.len : b.wid) / 3;
        rz = longint'(b.hgt) / 2;
        if ($urandom_range(0, 3) == 0) begin
            r  = r * 3 + 4;
            rz = rz * 2 + 4;
        end
        p.x = coord_clamp(longint'(b.x) + rand_offset(r));
        p.y = coord_clamp(longint'(b.y) + rand_offset(r));
        p.z = coord_clamp(longint'(b.z) + rand_offset(rz));
        return p;
    endfunction

    task automatic send_item(input stim_item_t it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_opcode     <= it.opcode;
        s_pos_x      <= it.x;
        s_pos_y      <= it.y;
        s_pos_z      <= it.z;
        s_box_length <= it.len;
        s_box_width  <= it.wid;
        s_box_height <= it.hgt;
        s_rot_cos    <= it.rc;
        s_rot_sin    <= it.rs;
        do @(posedge aclk); while (!(s_valid && s_ready));
        items_sent++;
        op_count[it.opcode]++;
        if (items_sent == 150)
            hold_req = 1'b1;
        if (it.opcode == OP_CLEAR)
            shadow_fill = 0;
        else if (it.opcode == OP_LOAD && shadow_fill < MAX_BOXES_DEF) begin
            shadow_box[shadow_fill] = it;
            shadow_fill++;
        end
    endtask

    // Receiver: one long hold-off once, otherwise alternating ready patterns.
    always @(negedge aclk) begin
        if (hold_req && !hold_done) begin
            m_ready <= 1'b0;
            hold_left++;
            if (hold_left == HOLD_CYCLES)
                hold_done = 1'b1;
        end else begin
            if (rx_phase_left == 0) begin
                rx_mode       = $urandom_range(0, 2);
                rx_phase_left = $urandom_range(20, 80);
            end
            rx_phase_left--;
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                default: begin
                    if (rx_stall_left > 0) begin
                        m_ready <= 1'b0;
                        rx_stall_left--;
                    end else begin
                        m_ready <= 1'b1;
                        if ($urandom_range(0, 3) == 0)
                            rx_stall_left = $urandom_range(1, 12);
                    end
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        stim_item_t it;
        int         directed_sent;
        int         nload;
        int         nq;
        int         k;
        foreach (op_count[i])
            op_count[i] = 0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // Classify against an empty table, then an unused opcode.
        send_item(make_item(OP_CLASSIFY, 524287, -524288, 0, 0, 0, 0, 0, 0));
        it = random_item();
        it.opcode = OP_UNUSED;
        send_item(it);

        // Axis-aligned box; probe exactly on the faces and one step past.
        send_item(make_item(OP_LOAD, 0, 0, 0, 512, 256, 100, 16384, 0));
        send_item(make_item(OP_CLASSIFY, 256, 0, 50, 0, 0, 0, 0, 0));
        send_item(make_item(OP_CLASSIFY, 257, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_CLASSIFY, 0, -128, -51, 0, 0, 0, 0, 0));

        // Quarter turn with full height.
        send_item(make_item(OP_LOAD, 1000, 1000, 0, 200, 100, 65535, 0, 16384));
        send_item(make_item(OP_CLASSIFY, 1000, 1100, -32767, 0, 0, 0, 0, 0));

        // Extreme centre, sizes and rotation values outside unit range.
        send_item(make_item(OP_LOAD, -524288, -524288, -524288, 65535, 65535, 65535,
                            32767, -32768));
        send_item(make_item(OP_CLASSIFY, 524287, 524287, 524287, 0, 0, 0, 0, 0));
        send_item(make_item(OP_CLASSIFY, -524288, -524288, -524288, 0, 0, 0, 0, 0));

        // Overlapping boxes: the first match must win.
        send_item(make_item(OP_LOAD, 0, 0, 0, 2000, 2000, 2000, -16384, 0));
        send_item(make_item(OP_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_CLASSIFY, 600, 0, 0, 0, 0, 0, 0, 0));

        // Zero-size box still holds its own centre.
        send_item(make_item(OP_LOAD, 5000, 5000, 5000, 0, 0, 0, 16384, 0));
        send_item(make_item(OP_CLASSIFY, 5000, 5000, 5000, 0, 0, 0, 0, 0));

        // Fill the table, overflow it, hit the last slot, then clear.
        for (k = 5; k < 16; k++)
            send_item(make_item(OP_LOAD, k * 4096, -100000, 0, 1000, 1000, 1000,
                                16384, 0));
        send_item(make_item(OP_LOAD, 1, 2, 3, 1, 1, 1, 1, 1));
        send_item(make_item(OP_CLASSIFY, 61440, -100000, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(OP_CLASSIFY, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_sent = items_sent;

        // Random part: mostly load-then-query sequences, some noise beats.
        while (items_sent - directed_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                send_item(random_item());
            end else begin
                if (shadow_fill == 0 || $urandom_range(0, 2) != 0) begin
                    it = random_item();
                    it.opcode = OP_CLEAR;
                    send_item(it);
                end
                nload = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 18)
                                                    : $urandom_range(1, 5);
                repeat (nload)
                    send_item(random_box());
                nq = $urandom_range(2, 10);
                repeat (nq) begin
                    if (shadow_fill != 0 && $urandom_range(0, 4) != 0) begin
                        send_item(point_near(shadow_box[$urandom_range(0, shadow_fill - 1)]));
                    end else begin
                        it = random_item();
                        it.opcode = OP_CLASSIFY;
                        send_item(it);
                    end
                end
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d beats: %0d clears, %0d loads (%0d dropped on a full table),",
                 items_sent, op_count[OP_CLEAR], op_count[OP_LOAD], drop_total);
        $display("%0d point queries (%0d inside a box), %0d unused-opcode beats",
                 op_count[OP_CLASSIFY], hit_total, op_count[OP_UNUSED]);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
